// ----- rtl/mbs_pkg.sv -----
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants for the Modbus TCP register server.
// ----------------------------------------------------------------------------
package mbs_pkg;

  localparam int FRAME_BYTES = 12;

  localparam logic [7:0]  FC_READ        = 8'h04;
  localparam logic [7:0]  FC_WRITE       = 8'h06;
  localparam logic [15:0] LEN_REQ        = 16'd6;
  localparam logic [15:0] LEN_RSP_BASE   = 16'd3;
  localparam logic [7:0]  UNIT_ID_RST    = 8'hFF;
  localparam logic [15:0] PROTOCOL_RST   = 16'h0000;
  localparam logic [3:0]  IDX_COUNT      = 4'd8;
  localparam logic [3:0]  IDX_FRAME_LAST = 4'd11;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_PROTO   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN     = 3'd2;
  localparam logic [2:0] ST_BAD_FUNC    = 3'd3;
  localparam logic [2:0] ST_NOT_HANDLED = 3'd4;

  localparam logic [1:0] REG_UNIT_ID     = 2'd0;
  localparam logic [1:0] REG_PROTOCOL_ID = 2'd1;
  localparam logic [1:0] REG_SERVER_MODE = 2'd2;

  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_LOAD     = 2'd1,
    OP_BUILD_WR = 2'd2,
    OP_BUILD_RD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_WR,
    KIND_RD_REQ,
    KIND_RD_RSP
  } kind_t;

  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_WHI,
    SEL_WLO,
    SEL_STAT
  } sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_STAT,
    S_EMIT,
    S_SCAN,
    S_SCAN_END,
    S_WRITE,
    S_WHI,
    S_WLO
  } state_t;

  typedef struct packed {
    logic [7:0]  unit_id;
    logic [15:0] protocol_id;
    logic        server_mode;
  } cfg_t;

  typedef struct packed {
    logic       in_take;
    logic       push;
    sel_t       sel;
    logic [3:0] idx;
    logic       last;
    logic [2:0] status;
    logic       frame_close;
    logic       scan_rd;
    logic       tbl_wr;
    logic       word_clr;
    logic       word_inc;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       proto_ok;
    logic       server;
    logic       len_ok;
    logic [7:0] fc;
    logic       rsp_kind;
    logic       scan_last;
    logic       cnt_zero;
    logic       last_word;
  } sts_t;

endpackage

// ----- rtl/mbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbs_ctrl
// Sequencer: frame checks, table scans and the order of sent bytes.
// ----------------------------------------------------------------------------
module mbs_ctrl
  import mbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic       in_rx_last,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [2:0] stat_r, stat_nxt;
  opcode_t    op;

  assign op = opcode_t'(in_opcode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      stat_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    stat_nxt   = stat_r;
    cmd        = '0;
    cmd.sel    = SEL_HDR;
    cmd.idx    = idx_r;
    cmd.status = stat_r;
    in_stall   = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.in_take = in_valid;
        if (in_valid) begin
          unique case (op)
            OP_RX_BYTE:  if (in_rx_last) state_nxt = S_CHECK;
            OP_LOAD:     state_nxt = S_IDLE;
            OP_BUILD_WR,
            OP_BUILD_RD: begin
              idx_nxt   = '0;
              state_nxt = S_EMIT;
            end
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        cmd.frame_close = 1'b1;
        // a write lookup uses the word offset too, so start it at zero
        cmd.word_clr    = 1'b1;
        idx_nxt         = '0;
        priority if (!sts.proto_ok) begin
          stat_nxt  = ST_BAD_PROTO;
          state_nxt = S_STAT;
        end else if (!sts.server) begin
          stat_nxt  = ST_NOT_HANDLED;
          state_nxt = S_STAT;
        end else if (!sts.len_ok) begin
          stat_nxt  = ST_BAD_LEN;
          state_nxt = S_STAT;
        end else if (sts.fc == FC_READ) begin
          state_nxt = S_EMIT;
        end else if (sts.fc == FC_WRITE) begin
          state_nxt = S_SCAN;
        end else begin
          stat_nxt  = ST_BAD_FUNC;
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          cmd.sel   = SEL_STAT;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          idx_nxt  = idx_r + 4'd1;
          if (sts.rsp_kind) begin
            if (idx_r == IDX_COUNT) begin
              cmd.last     = sts.cnt_zero;
              cmd.word_clr = 1'b1;
              state_nxt    = sts.cnt_zero ? S_IDLE : S_SCAN;
            end
          end else if (idx_r == IDX_FRAME_LAST) begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        // last compare lands this cycle
        state_nxt = sts.rsp_kind ? S_WHI : S_WRITE;
      end
      S_WRITE: begin
        cmd.tbl_wr = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_EMIT;
      end
      S_WHI: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          cmd.sel   = SEL_WHI;
          state_nxt = S_WLO;
        end
      end
      S_WLO: begin
        if (sts.out_free) begin
          cmd.push     = 1'b1;
          cmd.sel      = SEL_WLO;
          cmd.last     = sts.last_word;
          cmd.word_inc = !sts.last_word;
          state_nxt    = sts.last_word ? S_IDLE : S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/mbs_dp.sv -----
// ----------------------------------------------------------------------------
// mbs_dp
// Datapath: receive buffer, register table, frame fields and output register.
// ----------------------------------------------------------------------------
module mbs_dp
  import mbs_pkg::*;
#(
  parameter int NUM_REGS      = 16,
  parameter int MAX_READ_REGS = 27
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_reg_address,
  input  logic [15:0] in_reg_value,
  input  logic [15:0] in_read_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_has_byte,
  output logic        out_last_byte,
  output logic [2:0]  out_status
);

  localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CW = $clog2(MAX_READ_REGS + 1);

  opcode_t op;
  assign op = opcode_t'(in_opcode);

  // receive buffer
  logic [7:0] rx_bytes_r [FRAME_BYTES];
  logic [3:0] rx_count_r;
  logic       rx_wr;

  assign rx_wr = cmd.in_take && (op == OP_RX_BYTE) && (rx_count_r < 4'(FRAME_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.frame_close) begin
      for (int i = 0; i < FRAME_BYTES; i++) rx_bytes_r[i] <= '0;
      rx_count_r <= '0;
    end else if (rx_wr) begin
      rx_bytes_r[rx_count_r] <= in_rx_byte;
      rx_count_r             <= rx_count_r + 4'd1;
    end
  end

  logic [15:0] rx_txid, rx_proto, rx_len, rx_addr, rx_val;
  assign rx_txid  = {rx_bytes_r[0], rx_bytes_r[1]};
  assign rx_proto = {rx_bytes_r[2], rx_bytes_r[3]};
  assign rx_len   = {rx_bytes_r[4], rx_bytes_r[5]};
  assign rx_addr  = {rx_bytes_r[8], rx_bytes_r[9]};
  assign rx_val   = {rx_bytes_r[10], rx_bytes_r[11]};

  logic proto_ok;
  assign proto_ok = (rx_proto == cfg.protocol_id);

  // transaction id and frame fields
  logic [15:0]   txid_r;
  kind_t         kind_r;
  logic [15:0]   addr_r;
  logic [15:0]   arg_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_clamp;

  assign cnt_clamp = (rx_val > 16'(MAX_READ_REGS)) ? CW'(MAX_READ_REGS) : rx_val[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txid_r <= '0;
      kind_r <= KIND_WR;
    end else if (cmd.frame_close) begin
      if (proto_ok) txid_r <= rx_txid + 16'd1;
      kind_r <= (rx_bytes_r[7] == FC_READ) ? KIND_RD_RSP : KIND_WR;
    end else if (cmd.in_take && op == OP_BUILD_WR) begin
      kind_r <= KIND_WR;
    end else if (cmd.in_take && op == OP_BUILD_RD) begin
      kind_r <= KIND_RD_REQ;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_close) begin
      addr_r <= rx_addr;
      arg_r  <= rx_val;
      cnt_r  <= cnt_clamp;
    end else if (cmd.in_take && (op == OP_BUILD_WR || op == OP_BUILD_RD)) begin
      addr_r <= in_reg_address;
      arg_r  <= (op == OP_BUILD_WR) ? in_reg_value : in_read_count;
    end
  end

  // word counter for read responses
  logic [CW-1:0] w_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.word_clr) w_r <= '0;
    else if (cmd.word_inc)      w_r <= w_r + CW'(1);
  end

  // register table: address in the upper half, value in the lower
  logic [31:0]       tbl_mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_r;
  logic [IW:0]       scan_cnt_r;
  logic [IW-1:0]     rd_idx, rd_idx_r, hit_idx_r;
  logic [31:0]       rd_data_r;
  logic              rd_vld_r;
  logic              found_r;
  logic [15:0]       word_val_r;
  logic [16:0]       target;
  logic              hit;
  logic [6:0]        slot_x;
  logic              load_ok;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic [31:0]       mem_wd;

  assign slot_x  = 7'(in_slot);
  assign load_ok = cmd.in_take && (op == OP_LOAD) && (slot_x < 7'(NUM_REGS));
  assign mem_we  = load_ok || (cmd.tbl_wr && found_r);
  assign mem_wa  = load_ok ? slot_x[IW-1:0] : hit_idx_r;
  assign mem_wd  = load_ok ? {in_reg_address, in_reg_value} : {addr_r, arg_r};

  assign rd_idx  = scan_cnt_r[IW-1:0];
  // addresses past the top of the map never match
  assign target  = 17'(addr_r) + 17'(w_r);
  assign hit     = rd_vld_r && !target[16] && (rd_data_r[31:16] == target[15:0]);

  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem[mem_wa] <= mem_wd;
    if (cmd.scan_rd) rd_data_r <= tbl_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (load_ok) valid_r[slot_x[IW-1:0]] <= 1'b1;
      scan_cnt_r <= cmd.scan_rd ? scan_cnt_r + (IW+1)'(1) : '0;
      rd_vld_r   <= cmd.scan_rd && valid_r[rd_idx];
      if (cmd.scan_rd && scan_cnt_r == '0) begin
        found_r <= 1'b0;
      end else if (hit && !found_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx;
    if (hit && !found_r) begin
      word_val_r <= rd_data_r[15:0];
      hit_idx_r  <= rd_idx_r;
    end
  end

  // byte selection
  logic [15:0] word_out, len_out;
  logic [7:0]  fc_out, cnt_byte, hdr_byte, byte_sel;

  assign word_out = found_r ? word_val_r : 16'd0;
  assign len_out  = (kind_r == KIND_RD_RSP) ? ((16'(cnt_r) << 1) + LEN_RSP_BASE) : LEN_REQ;
  assign fc_out   = (kind_r == KIND_WR) ? FC_WRITE : FC_READ;
  assign cnt_byte = 8'(cnt_r) << 1;

  always_comb begin
    unique case (cmd.idx)
      4'd0:    hdr_byte = txid_r[15:8];
      4'd1:    hdr_byte = txid_r[7:0];
      4'd2:    hdr_byte = cfg.protocol_id[15:8];
      4'd3:    hdr_byte = cfg.protocol_id[7:0];
      4'd4:    hdr_byte = len_out[15:8];
      4'd5:    hdr_byte = len_out[7:0];
      4'd6:    hdr_byte = cfg.unit_id;
      4'd7:    hdr_byte = fc_out;
      4'd8:    hdr_byte = (kind_r == KIND_RD_RSP) ? cnt_byte : addr_r[15:8];
      4'd9:    hdr_byte = addr_r[7:0];
      4'd10:   hdr_byte = arg_r[15:8];
      4'd11:   hdr_byte = arg_r[7:0];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_HDR:  byte_sel = hdr_byte;
      SEL_WHI:  byte_sel = word_out[15:8];
      SEL_WLO:  byte_sel = word_out[7:0];
      SEL_STAT: byte_sel = 8'd0;
      default:  byte_sel = 8'd0;
    endcase
  end

  // output register
  logic       out_valid_r;
  logic [7:0] out_tx_byte_r;
  logic       out_has_byte_r, out_last_byte_r;
  logic [2:0] out_status_r;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (cmd.push) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_tx_byte_r   <= byte_sel;
      out_has_byte_r  <= (cmd.sel != SEL_STAT);
      out_last_byte_r <= cmd.last;
      out_status_r    <= (cmd.sel == SEL_STAT) ? cmd.status : ST_OK;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_has_byte  = out_has_byte_r;
  assign out_last_byte = out_last_byte_r;
  assign out_status    = out_status_r;

  always_comb begin
    sts.out_free  = out_free;
    sts.proto_ok  = proto_ok;
    sts.server    = cfg.server_mode;
    sts.len_ok    = (rx_len == LEN_REQ);
    sts.fc        = rx_bytes_r[7];
    sts.rsp_kind  = (kind_r == KIND_RD_RSP);
    sts.scan_last = (scan_cnt_r == (IW+1)'(NUM_REGS - 1));
    sts.cnt_zero  = (cnt_r == '0);
    sts.last_word = (w_r == cnt_r - CW'(1));
  end

endmodule

// ----- rtl/modbus_tcp_register_server.sv -----
// ----------------------------------------------------------------------------
// modbus_tcp_register_server
// Modbus TCP server/client frame engine for single-register write and reads.
// ----------------------------------------------------------------------------
// Request bytes are taken one per cycle; the byte marked last starts a check
// cycle and the block takes no new item until its answer has been handed to
// the output register. Header, echo and built request bytes leave at one per
// cycle while the output is not stalled. Each table lookup is a scan over the
// table memory, one entry per cycle through its single read port; a function 6
// write scans once before its echo and a function 4 answer scans once per
// returned register word. A table load writes its slot directly, with no scan.
module modbus_tcp_register_server
  import mbs_pkg::*;
#(
  parameter int NUM_REGS      = 16,
  parameter int MAX_READ_REGS = 27
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_reg_address,
  input  logic [15:0] in_reg_value,
  input  logic [15:0] in_read_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_has_byte,
  output logic        out_last_byte,
  output logic [2:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_id     <= UNIT_ID_RST;
      cfg_r.protocol_id <= PROTOCOL_RST;
      cfg_r.server_mode <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_UNIT_ID:     cfg_r.unit_id     <= pwdata[7:0];
        REG_PROTOCOL_ID: cfg_r.protocol_id <= pwdata[15:0];
        REG_SERVER_MODE: cfg_r.server_mode <= pwdata[0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_UNIT_ID:     prdata = 32'(cfg_r.unit_id);
      REG_PROTOCOL_ID: prdata = 32'(cfg_r.protocol_id);
      REG_SERVER_MODE: prdata = 32'(cfg_r.server_mode);
      default:         prdata = 32'd0;
    endcase
  end

  mbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_rx_last (in_rx_last),
    .sts        (sts),
    .cmd        (cmd)
  );

  mbs_dp #(
    .NUM_REGS      (NUM_REGS),
    .MAX_READ_REGS (MAX_READ_REGS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_rx_byte     (in_rx_byte),
    .in_slot        (in_slot),
    .in_reg_address (in_reg_address),
    .in_reg_value   (in_reg_value),
    .in_read_count  (in_read_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_has_byte   (out_has_byte),
    .out_last_byte  (out_last_byte),
    .out_status     (out_status)
  );

endmodule

// ----- rtl/mbs_chk.sv -----
// ----------------------------------------------------------------------------
// mbs_chk
// Port-level checks for the Modbus TCP register server.
// ----------------------------------------------------------------------------
module mbs_chk
  import mbs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_byte,
  input logic       out_has_byte,
  input logic       out_last_byte,
  input logic [2:0] out_status,
  input logic       pready
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_last_byte))
    else $error("stalled output beat changed");

  // a status-only beat closes its run and carries no byte
  a_stat_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last_byte && out_tx_byte == 8'd0 && out_status != ST_OK)
    else $error("malformed status beat");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> out_status == ST_OK)
    else $error("frame byte with error status");

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind modbus_tcp_register_server mbs_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tx_byte   (out_tx_byte),
  .out_has_byte  (out_has_byte),
  .out_last_byte (out_last_byte),
  .out_status    (out_status),
  .pready        (pready)
);
